@@ rtl/core/frwm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate window monitor package
// Shared widths, register indexes, arithmetic constants and the command and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package frwm_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FPS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_TILES     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TILES     = 2'd3;

  // Register widths and reset values.
  localparam int TARGET_W = 10;
  localparam int WLEN_W   = 7;
  localparam int TILES_W  = 10;

  localparam logic [TARGET_W-1:0] TARGET_FPS_RESET    = 10'd60;
  localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RESET = 7'd64;
  localparam logic [TILES_W-1:0]  MIN_TILES_RESET     = 10'd1;
  localparam logic [TILES_W-1:0]  MAX_TILES_RESET     = 10'd8;

  // Rate result: unsigned Q8 frames per second.
  localparam int RATE_W = 28;
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;
  localparam logic [RATE_W-1:0] RATE_SCALE = 28'd256000000;  // 1e6 us * 256

  // Band thresholds against the target, in Q8. The top band is 0.92 of the
  // target, compared as 25 * rate >= 23 * 256 * target.
  localparam int TOP_BAND_DIV  = 25;
  localparam int TOP_BAND_MUL  = 5888;
  localparam int LOW_BAND_MUL  = 192;
  localparam int CRIT_BAND_MUL = 128;

  // Tile budget scaling: round(max * 0.66) and round(max * 0.33), computed as
  // (max * k + 50) / 100. The divide by 100 is a multiply by a reciprocal
  // that is exact for every product below 2^17.
  localparam int TILE_PROD_W    = 17;
  localparam int TILE_HIGH_MUL  = 66;
  localparam int TILE_MID_MUL   = 33;
  localparam int TILE_ROUND     = 50;
  localparam int TILE_RECIP_W   = 18;
  localparam int TILE_RECIP     = 167773;  // ceil(2^24 / 100)
  localparam int TILE_SHIFT     = 24;

  typedef struct packed {
    logic capture;    // latch the sample, decide the drop, read the oldest slot
    logic update;     // write the sample and update count and total
    logic scale;      // form count * 256e6
    logic check;      // load the divider and the tile products
    logic div_step;   // one restoring division step
    logic rate;       // register the rate and the scaled tile budgets
    logic load_out;   // compute flags and budget into the result register
  } frwm_cmd_t;

  typedef struct packed {
    logic saturate;   // zero total or quotient does not fit the rate field
  } frwm_status_t;

endpackage

@@ rtl/core/frwm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate window monitor controller
// Sequences one item through window update, scaling, division and banding,
// and owns the input stall and the result valid.
// ----------------------------------------------------------------------------
module frwm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  frwm_pkg::frwm_status_t status,
  output frwm_pkg::frwm_cmd_t    cmd
);

  localparam int CNT_W = $clog2(frwm_pkg::RATE_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(frwm_pkg::RATE_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCALE,
    S_CHECK,
    S_DIV,
    S_RATE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] div_cnt;
  logic             accept;
  logic             out_free;

  assign accept   = (state == S_IDLE) && in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.update   = (state == S_UPDATE);
    cmd.scale    = (state == S_SCALE);
    cmd.check    = (state == S_CHECK);
    cmd.div_step = (state == S_DIV);
    cmd.rate     = (state == S_RATE);
    cmd.load_out = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            in_stall <= 1'b1;
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          div_cnt <= '0;
          if (status.saturate) begin
            state <= S_RATE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            state <= S_RATE;
          end
        end
        S_RATE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            in_stall <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/frwm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate window monitor datapath
// Sample ring memory, running total, configuration registers, restoring
// divider for the rate and the band and tile budget logic.
// ----------------------------------------------------------------------------
module frwm_datapath #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  frwm_pkg::frwm_cmd_t                  cmd,
  output frwm_pkg::frwm_status_t               status,
  input  logic                                 cfg_we,
  input  logic [frwm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [frwm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [SAMPLE_BITS-1:0]               frame_time_us,
  output logic [frwm_pkg::RATE_W-1:0]          rate_fps_q8,
  output logic                                 rate_low,
  output logic                                 rate_critical,
  output logic [frwm_pkg::TILES_W-1:0]         tile_budget
);

  localparam int RATE_W = frwm_pkg::RATE_W;
  localparam int TILES_W = frwm_pkg::TILES_W;
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int TW = SAMPLE_BITS + AW;
  localparam int NW = CW + RATE_W;
  localparam int SW = CW + 1;
  localparam int LW = (CW > frwm_pkg::WLEN_W) ? CW : frwm_pkg::WLEN_W;
  localparam int R25_W = RATE_W + 5;
  localparam int TILE_QW = frwm_pkg::TILE_PROD_W + frwm_pkg::TILE_RECIP_W;

  // Configuration registers.
  logic [frwm_pkg::TARGET_W-1:0] target_fps;
  logic [frwm_pkg::WLEN_W-1:0]   window_length;
  logic [TILES_W-1:0]            min_tiles;
  logic [TILES_W-1:0]            max_tiles;

  // Window state.
  logic [SAMPLE_BITS-1:0] sample_store [WINDOW_MAX];
  logic [AW-1:0]          oldest_slot;
  logic [CW-1:0]          sample_count;
  logic [TW-1:0]          running_total;

  // Per-item working registers.
  logic [SAMPLE_BITS-1:0]         sample;
  logic                           drop;
  logic [SAMPLE_BITS-1:0]         rd_data;
  logic [NW-1:0]                  num;
  logic [TW-1:0]                  rem;
  logic [RATE_W-1:0]              quo;
  logic                           sat;
  logic [frwm_pkg::TILE_PROD_W-1:0] p_high;
  logic [frwm_pkg::TILE_PROD_W-1:0] p_mid;
  logic [RATE_W-1:0]              rate;
  logic [TILES_W-1:0]             s_high;
  logic [TILES_W-1:0]             s_mid;

  // Combinational helpers.
  logic [LW-1:0]      eff_len;
  logic               drop_now;
  logic [SW-1:0]      slot_sum;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      oldest_inc;
  logic [TW-1:0]      total_next;
  logic               sat_now;
  logic [TW:0]        div_shift;
  logic [TW:0]        div_diff;
  logic [TILE_QW-1:0] q_high;
  logic [TILE_QW-1:0] q_mid;
  logic [R25_W-1:0]   r25;
  logic [R25_W-1:0]   t_top;
  logic [RATE_W-1:0]  t_low;
  logic [RATE_W-1:0]  t_crit;
  logic               ge_top;
  logic               ge_low;
  logic               ge_crit;
  logic [TILES_W-1:0] budget;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_fps    <= frwm_pkg::TARGET_FPS_RESET;
      window_length <= frwm_pkg::WINDOW_LENGTH_RESET;
      min_tiles     <= frwm_pkg::MIN_TILES_RESET;
      max_tiles     <= frwm_pkg::MAX_TILES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        frwm_pkg::REG_TARGET_FPS:    target_fps    <= cfg_data[frwm_pkg::TARGET_W-1:0];
        frwm_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[frwm_pkg::WLEN_W-1:0];
        frwm_pkg::REG_MIN_TILES:     min_tiles     <= cfg_data[TILES_W-1:0];
        frwm_pkg::REG_MAX_TILES:     max_tiles     <= cfg_data[TILES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero length acts as one; a length above the ring acts as the ring size.
  always_comb begin
    if (window_length == '0) begin
      eff_len = LW'(1);
    end else if (LW'(window_length) > LW'(WINDOW_MAX)) begin
      eff_len = LW'(WINDOW_MAX);
    end else begin
      eff_len = LW'(window_length);
    end
  end

  assign drop_now = (sample_count != '0) && (LW'(sample_count) >= eff_len);

  // The new sample lands at oldest + count either way: a drop advances the
  // oldest slot and shortens the count by one.
  always_comb begin
    slot_sum = SW'(oldest_slot) + SW'(sample_count);
    if (slot_sum >= SW'(WINDOW_MAX)) begin
      slot_sum = slot_sum - SW'(WINDOW_MAX);
    end
    wr_addr = slot_sum[AW-1:0];
  end

  assign oldest_inc = (oldest_slot == AW'(WINDOW_MAX - 1)) ? '0 : oldest_slot + 1'b1;
  assign total_next = running_total - (drop ? TW'(rd_data) : '0) + TW'(sample);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data <= sample_store[oldest_slot];
    end
    if (cmd.update) begin
      sample_store[wr_addr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot   <= '0;
      sample_count  <= '0;
      running_total <= '0;
    end else if (cmd.update) begin
      running_total <= total_next;
      if (drop) begin
        oldest_slot <= oldest_inc;
      end else begin
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  // The quotient fits the rate field only if the part of the numerator above
  // the rate width is below the total.
  assign sat_now = (running_total == '0) || (TW'(num[NW-1:RATE_W]) >= running_total);
  assign status.saturate = sat_now;

  assign div_shift = {rem, quo[RATE_W-1]};
  assign div_diff  = div_shift - {1'b0, running_total};

  assign q_high = TILE_QW'(p_high) * TILE_QW'(frwm_pkg::TILE_RECIP);
  assign q_mid  = TILE_QW'(p_mid) * TILE_QW'(frwm_pkg::TILE_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= frame_time_us;
      drop   <= drop_now;
    end
    if (cmd.scale) begin
      num <= NW'(sample_count) * NW'(frwm_pkg::RATE_SCALE);
    end
    if (cmd.check) begin
      sat    <= sat_now;
      rem    <= TW'(num[NW-1:RATE_W]);
      quo    <= num[RATE_W-1:0];
      p_high <= frwm_pkg::TILE_PROD_W'(max_tiles) * frwm_pkg::TILE_PROD_W'(frwm_pkg::TILE_HIGH_MUL)
                + frwm_pkg::TILE_PROD_W'(frwm_pkg::TILE_ROUND);
      p_mid  <= frwm_pkg::TILE_PROD_W'(max_tiles) * frwm_pkg::TILE_PROD_W'(frwm_pkg::TILE_MID_MUL)
                + frwm_pkg::TILE_PROD_W'(frwm_pkg::TILE_ROUND);
    end
    if (cmd.div_step) begin
      if (!div_diff[TW]) begin
        rem <= div_diff[TW-1:0];
        quo <= {quo[RATE_W-2:0], 1'b1};
      end else begin
        rem <= div_shift[TW-1:0];
        quo <= {quo[RATE_W-2:0], 1'b0};
      end
    end
    if (cmd.rate) begin
      rate   <= sat ? frwm_pkg::RATE_MAX : quo;
      s_high <= q_high[frwm_pkg::TILE_SHIFT +: TILES_W];
      s_mid  <= q_mid[frwm_pkg::TILE_SHIFT +: TILES_W];
    end
  end

  // Band decision on the final rate, then the min/max clamp.
  always_comb begin
    r25     = R25_W'(rate) * R25_W'(frwm_pkg::TOP_BAND_DIV);
    t_top   = R25_W'(target_fps) * R25_W'(frwm_pkg::TOP_BAND_MUL);
    t_low   = RATE_W'(target_fps) * RATE_W'(frwm_pkg::LOW_BAND_MUL);
    t_crit  = RATE_W'(target_fps) * RATE_W'(frwm_pkg::CRIT_BAND_MUL);
    ge_top  = (r25 >= t_top);
    ge_low  = (rate >= t_low);
    ge_crit = (rate >= t_crit);
    if (ge_top) begin
      budget = max_tiles;
    end else if (ge_low) begin
      budget = (s_high < min_tiles) ? min_tiles : s_high;
    end else if (ge_crit) begin
      budget = (s_mid < min_tiles) ? min_tiles : s_mid;
    end else begin
      budget = min_tiles;
    end
    if (budget < min_tiles) begin
      budget = min_tiles;
    end else if (!(budget < max_tiles)) begin
      budget = max_tiles;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rate_fps_q8   <= rate;
      rate_low      <= !ge_low;
      rate_critical <= !ge_crit;
      tile_budget   <= budget;
    end
  end

endmodule

@@ rtl/core/frame_rate_window_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate window monitor
// Moving average of frame durations over a ring window, reported as a Q8
// frame rate with low and critical flags and a recommended tile budget.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer carries one frame duration in microseconds. It enters
// the ring window, the oldest sample leaves when the window is full, and the
// block returns exactly one result transfer: the average rate in Q8 fps, two
// flags against the target rate and a tile budget for the next frame.
// Both data channels use valid and stall; a transfer happens when valid is
// high and stall is low. Configuration registers are written over a separate
// valid/ready channel that is always ready; write them only while idle.
// An item passes through the window update, scaling, the check, the 28 steps
// of the restoring divider, the rate register and the result load; with a zero
// total or an overflowing rate the divider is skipped. One item is in work at
// a time, so a new item is taken only after the previous result is loaded.
// The result sits in an output register, so a stalled receiver does not
// block the next input; the block only waits before loading a new result
// while the previous one is still held. Reset empties the window, zeroes the
// running total and restores the register defaults; the sample memory itself
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_rate_window_monitor #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input item channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SAMPLE_BITS-1:0]           frame_time_us,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [frwm_pkg::RATE_W-1:0]      rate_fps_q8,
  output logic                             rate_low,
  output logic                             rate_critical,
  output logic [frwm_pkg::TILES_W-1:0]     tile_budget,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [frwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [frwm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  frwm_pkg::frwm_cmd_t    cmd;
  frwm_pkg::frwm_status_t status;

  // Registers take a write in any cycle; the controller never holds it off.
  assign cfg_ready = 1'b1;

  frwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  frwm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .frame_time_us (frame_time_us),
    .rate_fps_q8   (rate_fps_q8),
    .rate_low      (rate_low),
    .rate_critical (rate_critical),
    .tile_budget   (tile_budget)
  );

endmodule

@@ rtl/core/frwm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate window monitor checker
// Port-level properties of the monitor, attached to every instance by bind.
// ----------------------------------------------------------------------------
module frwm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [frwm_pkg::RATE_W-1:0]  rate_fps_q8,
  input logic                         rate_low,
  input logic                         rate_critical,
  input logic [frwm_pkg::TILES_W-1:0] tile_budget
);

  // A result held by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A result held by the receiver keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(rate_fps_q8) && $stable(rate_low) &&
      $stable(rate_critical) && $stable(tile_budget))
    else $error("result payload changed while stalled");

  // Below half the target is also below three quarters of it.
  a_flag_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_critical |-> rate_low)
    else $error("critical flag without low flag");

  // One item at a time: an input transfer closes the input channel.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_rate_window_monitor frwm_checker u_frwm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .rate_fps_q8   (rate_fps_q8),
  .rate_low      (rate_low),
  .rate_critical (rate_critical),
  .tile_budget   (tile_budget)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate window monitor testbench
// Sends frame durations through the monitor while both sides idle and stall at
// random. A model of the ring window, the running total and the registers
// predicts every report. Each report is checked field by field: rate, flags
// and tile budget.
// ----------------------------------------------------------------------------
module testbench;
  import frwm_pkg::*;

  localparam int SLOTS         = 64;
  localparam int SAMPLE_W      = 20;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  // The receiver hold-off counts down from this value to fill the block up.
  localparam int HOLD_CYCLES   = 300;
  // Cycles without any transfer before the run is declared hung. The slowest
  // correct gap is the hold-off above plus one divide, so this is generous.
  localparam int STUCK_LIMIT   = 2000;
  localparam int RANDOM_FRAMES = 1250;
  // The drain outlasts the trail of a result behind its input transfer.
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic               low;
    logic               critical;
    logic [TILES_W-1:0] tiles;
  } fps_report_t;

  // Every DUT input starts at a known value.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    frame_time_us = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [RATE_W-1:0]      rate_fps_q8;
  logic                   rate_low;
  logic                   rate_critical;
  logic [TILES_W-1:0]     tile_budget;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_TARGET_FPS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Test knobs, changed only by the main sequence, and two bench counters.
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left;
  int   quiet_cycles;

  // Model of the window and the registers, updated from observed transfers.
  logic [SAMPLE_W-1:0] window_samples [SLOTS];
  int unsigned         head_slot;
  int unsigned         held_count;
  logic [63:0]         window_total;
  logic [TARGET_W-1:0] fps_target;
  logic [WLEN_W-1:0]   window_setting;
  logic [TILES_W-1:0]  tiles_floor;
  logic [TILES_W-1:0]  tiles_ceiling;

  fps_report_t expected_reports[$];

  int errors = 0;
  int frames_sent = 0;
  int reports_checked = 0;
  int reg_writes = 0;
  int saturated_reports = 0;
  int low_reports = 0;
  int critical_reports = 0;

  frame_rate_window_monitor #(
    .WINDOW_MAX (SLOTS),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_time_us(frame_time_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate_fps_q8  (rate_fps_q8),
    .rate_low     (rate_low),
    .rate_critical(rate_critical),
    .tile_budget  (tile_budget),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adds one frame to the modeled window and queues the report it must give.
  // The window gives up at most one sample per frame. After a shrinking
  // register write, the window therefore keeps its larger count of samples.
  function automatic void advance_window(input logic [SAMPLE_W-1:0] sample);
    int unsigned span;
    logic [63:0] rate;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] pick;
    fps_report_t report;
    // A length of zero behaves as one. Lengths past the store behave as full.
    span = (window_setting == 0) ? 1 :
           (window_setting > SLOTS) ? SLOTS : int'(window_setting);
    if (held_count >= SLOTS || held_count + 1 > span) begin
      if (held_count > 0) begin
        window_total = window_total - window_samples[head_slot];
        head_slot = (head_slot + 1) % SLOTS;
        held_count = held_count - 1;
      end
    end
    window_samples[(head_slot + held_count) % SLOTS] = sample;
    held_count = held_count + 1;
    window_total = window_total + sample;

    // Average rate in Q8 fps: count * 256e6 / total. It saturates when the
    // total is zero or when the quotient does not fit the 28-bit field.
    if (window_total == 0) begin
      rate = RATE_MAX;
    end else begin
      rate = (64'(held_count) * 64'd256000000) / window_total;
      if (rate > RATE_MAX) begin
        rate = RATE_MAX;
      end
    end

    // The tile bands are 0.92, 0.75 and 0.5 of the target. The top band is
    // tested as 25 * rate >= 23 * 256 * target. The middle budgets are
    // max * 0.66 and max * 0.33, rounded half up.
    target = fps_target;
    lo = tiles_floor;
    hi = tiles_ceiling;
    if (rate * 25 >= target * 5888) begin
      pick = hi;
    end else if (rate >= target * 192) begin
      pick = (hi * 66 + 50) / 100;
      if (pick < lo) pick = lo;
    end else if (rate >= target * 128) begin
      pick = (hi * 33 + 50) / 100;
      if (pick < lo) pick = lo;
    end else begin
      pick = lo;
    end
    // The final clamp puts the floor first. When min is above max, the top
    // band therefore gives min and the other bands give max.
    if (pick < lo) begin
      pick = lo;
    end else if (pick >= hi) begin
      pick = hi;
    end

    report.rate     = rate[RATE_W-1:0];
    report.low      = (rate < target * 192);
    report.critical = (rate < target * 128);
    report.tiles    = pick[TILES_W-1:0];
    expected_reports.push_back(report);
    if (report.rate == RATE_MAX) saturated_reports++;
    if (report.low) low_reports++;
    if (report.critical) critical_reports++;
  endfunction

  // Follows register writes and accepted frames in the order they happen.
  always @(posedge clk) begin
    if (rst) begin
      fps_target     = 10'd60;
      window_setting = 7'd64;
      tiles_floor    = 10'd1;
      tiles_ceiling  = 10'd8;
      head_slot      = 0;
      held_count     = 0;
      window_total   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_FPS:    fps_target = cfg_data[TARGET_W-1:0];
          REG_WINDOW_LENGTH: window_setting = cfg_data[WLEN_W-1:0];
          REG_MIN_TILES:     tiles_floor = cfg_data[TILES_W-1:0];
          REG_MAX_TILES:     tiles_ceiling = cfg_data[TILES_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_window(frame_time_us);
      end
    end
  end

  // Each result transfer is compared with the oldest queued report.
  always @(posedge clk) begin : check_reports
    fps_report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: rate_fps_q8 %0d, tile_budget %0d",
               rate_fps_q8, tile_budget);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (rate_fps_q8 !== want.rate) begin
          $error("rate_fps_q8 mismatch: expected %0d, got %0d", want.rate, rate_fps_q8);
          errors++;
        end
        if (rate_low !== want.low) begin
          $error("rate_low mismatch: expected %0d, got %0d", want.low, rate_low);
          errors++;
        end
        if (rate_critical !== want.critical) begin
          $error("rate_critical mismatch: expected %0d, got %0d",
                 want.critical, rate_critical);
          errors++;
        end
        if (tile_budget !== want.tiles) begin
          $error("tile_budget mismatch: expected %0d, got %0d", want.tiles, tile_budget);
          errors++;
        end
      end
    end
  end

  // Receiver side. A hold-off request keeps the result channel stalled for a
  // long stretch. Otherwise the channel stalls at the current random rate.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog. Any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STUCK_LIMIT) begin
      $display("no transfer for %0d cycles, %0d reports outstanding",
               quiet_cycles, expected_reports.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one frame after a random idle gap and holds it until it is taken.
  task automatic send_frame(input logic [SAMPLE_W-1:0] duration);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_time_us <= duration;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
  endtask

  // Stops sending and waits for every queued report. Every frame yields one
  // report, so the block is idle once the queue is empty. A few spare cycles
  // follow before any register write.
  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic configure(input int target, input int wlen, input int lo, input int hi);
    wait_reports_drained();
    write_reg(REG_TARGET_FPS, CFG_DATA_W'(target));
    write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(wlen));
    write_reg(REG_MIN_TILES, CFG_DATA_W'(lo));
    write_reg(REG_MAX_TILES, CFG_DATA_W'(hi));
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Most durations lie near the target frame time, scaled across the upper
  // three bands. The others are near zero, anywhere in the field, or near the top
  // of the field.
  function automatic logic [SAMPLE_W-1:0] pick_frame_time(input int unsigned target);
    int unsigned nominal;
    int unsigned scaled;
    nominal = 1000000 / ((target == 0) ? 60 : target);
    scaled  = nominal * $urandom_range(40, 160) / 100;
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'($urandom_range(0, 3));
      1: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      2: return SAMPLE_W'(SAMPLE_MAX - $urandom_range(0, 48575));
      default: return (scaled > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(scaled);
    endcase
  endfunction

  // These frames use the reset register values. The first frame has a zero
  // total. The second gives a quotient too large for the rate field. Then
  // come the largest field value and the nominal maximum.
  task automatic test_reset_defaults();
    send_frame(20'd0);
    send_frame(20'd1);
    send_frame(20'hFFFFF);
    send_frame(20'd1000000);
    wait_reports_drained();
  endtask

  // With a one-sample window, the rate is 256e6 divided by the frame time. At
  // a 60 fps target the four durations fall in the four bands. A 125 fps
  // target with 16000 us is exactly half the target, so it is not critical.
  task automatic test_tile_bands();
    configure(60, 1, 1, 8);
    send_frame(20'd16000);
    send_frame(20'd20000);
    send_frame(20'd30000);
    send_frame(20'd50000);
    configure(125, 1, 1, 8);
    send_frame(20'd16000);
    // Zero target: both flags clear and the top band is chosen, here with
    // min above max.
    configure(0, 1, 9, 4);
    send_frame(20'd50000);
    configure(60, 1, 9, 4);
    send_frame(20'd20000);
    send_frame(20'd50000);
    configure(1023, 1, 0, 1023);
    send_frame(20'hFFFFF);
    configure(60, 1, 0, 0);
    send_frame(20'd16000);
  endtask

  // A zero length behaves as one. The all-ones write masks to 127, which
  // behaves as a full window. Shrinking to two then trades one old sample for
  // each new frame, so the window keeps its size.
  task automatic test_window_limits();
    configure(60, 0, 1, 8);
    send_frame(20'd30000);
    send_frame(20'd10000);
    configure(60, 10'h3FF, 1, 8);
    send_frame(20'd12000);
    send_frame(20'd25000);
    send_frame(20'd40000);
    send_frame(20'd8000);
    configure(60, 2, 1, 8);
    send_frame(20'd17000);
    send_frame(20'd33000);
    send_frame(20'd21000);
    wait_reports_drained();
  endtask

  // The receiver holds off while frames keep coming, so the block fills up
  // and stalls its input. The sender then waits for the backlog to clear.
  task automatic test_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (16) send_frame(pick_frame_time(fps_target));
    wait_reports_drained();
  endtask

  // Runs of frames, each run under freshly drawn register values. The draws
  // favor the extremes, raw 10-bit window writes, and min above max.
  task automatic test_random_traffic(input int frames);
    int sent;
    int run_len;
    int target;
    int wlen;
    int lo;
    int hi;
    sent = 0;
    while (sent < frames) begin
      case ($urandom_range(0, 5))
        0: target = 0;
        1: target = 1;
        2: target = 1023;
        3: target = 1000;
        default: target = $urandom_range(1, 1000);
      endcase
      case ($urandom_range(0, 5))
        0: wlen = $urandom_range(0, 1023);
        1: wlen = 1;
        2: wlen = SLOTS;
        default: wlen = $urandom_range(1, SLOTS);
      endcase
      case ($urandom_range(0, 3))
        0: begin
          lo = $urandom_range(0, 1023);
          hi = $urandom_range(0, 1023);
        end
        1: begin
          lo = ($urandom_range(0, 1) != 0) ? 1023 : 0;
          hi = ($urandom_range(0, 1) != 0) ? 1023 : 0;
        end
        default: begin
          lo = $urandom_range(0, 16);
          hi = $urandom_range(lo, 64);
        end
      endcase
      configure(target, wlen, lo, hi);
      run_len = $urandom_range(10, 80);
      repeat (run_len) begin
        send_frame(pick_frame_time(target));
        sent++;
      end
    end
    wait_reports_drained();
  endtask

  // Main sequence. Reset is applied once. Directed tests run first, then
  // random runs under three idling profiles: sender light and receiver heavy,
  // then the reverse, then no idling.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(16, 77);
    test_reset_defaults();
    test_tile_bands();
    test_window_limits();
    test_random_traffic(RANDOM_FRAMES / 3);
    test_backpressure();

    set_idling(77, 16);
    test_random_traffic(RANDOM_FRAMES / 3);

    set_idling(0, 0);
    test_random_traffic(RANDOM_FRAMES / 3);
    test_backpressure();

    // Extra cycles catch any report that arrives without a matching frame.
    wait_reports_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frames, checked %0d reports, made %0d register writes.",
             frames_sent, reports_checked, reg_writes);
    $display("Reports with saturated rate: %0d, low flag: %0d, critical flag: %0d.",
             saturated_reports, low_reports, critical_reports);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ frame_rate_window_monitor.f @@
rtl/core/frwm_pkg.sv
rtl/core/frwm_ctrl.sv
rtl/core/frwm_datapath.sv
rtl/core/frame_rate_window_monitor.sv
rtl/core/frwm_checker.sv
tb/testbench.sv
